FILE: rtl/utcl_pkg.sv
// Package for the UTC to local date and hour converter.
// Field widths, the date record type and the month length table.
// No dependencies.
package utcl_pkg;

   localparam int YEAR_W  = 12;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int HOUR_W  = 5;
   localparam int OFF_W   = 5;

   localparam int HOURS_PER_DAY   = 24;
   localparam int MONTHS_PER_YEAR = 12;
   localparam int MAX_HOUR        = HOURS_PER_DAY - 1;
   localparam int OFF_MIN         = -12;
   localparam int OFF_MAX         = 14;

   localparam logic [MONTH_W-1:0] JANUARY  = MONTH_W'(1);
   localparam logic [MONTH_W-1:0] FEBRUARY = MONTH_W'(2);
   localparam logic [MONTH_W-1:0] DECEMBER = MONTH_W'(MONTHS_PER_YEAR);

   // y / 100 by reciprocal: (y * 5243) >> 19 is exact for 12-bit years
   localparam int                  DIV100_SHIFT = 19;
   localparam logic [12:0]         DIV100_MUL   = 13'd5243;

   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
      logic [HOUR_W-1:0]  hour;
   } date_type;

   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
      logic [DAY_W-1:0] days;
      case (month)
         4'd2:    days = leap ? DAY_W'(29) : DAY_W'(28);
         4'd4,
         4'd6,
         4'd9,
         4'd11:   days = DAY_W'(30);
         default: days = DAY_W'(31);
      endcase
      return days;
   endfunction

endpackage

FILE: rtl/utcl_req_if.sv
// Request channel: one UTC timestamp item with valid/ready.
// Depends on utcl_pkg.
interface utcl_req_if;
   logic                         valid;
   logic                         ready;
   logic [utcl_pkg::YEAR_W-1:0]  utc_year;
   logic [utcl_pkg::MONTH_W-1:0] utc_month;
   logic [utcl_pkg::DAY_W-1:0]   utc_day;
   logic [utcl_pkg::HOUR_W-1:0]  utc_hour;

   modport source (output valid, utc_year, utc_month, utc_day, utc_hour, input ready);
   modport sink   (input valid, utc_year, utc_month, utc_day, utc_hour, output ready);
endinterface

FILE: rtl/utcl_rsp_if.sv
// Response channel: one local date and hour item with valid/ready.
// Depends on utcl_pkg.
interface utcl_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [utcl_pkg::YEAR_W-1:0]  local_year;
   logic [utcl_pkg::MONTH_W-1:0] local_month;
   logic [utcl_pkg::DAY_W-1:0]   local_day;
   logic [utcl_pkg::HOUR_W-1:0]  local_hour;

   modport source (output valid, local_year, local_month, local_day, local_hour, input ready);
   modport sink   (input valid, local_year, local_month, local_day, local_hour, output ready);
endinterface

FILE: rtl/utcl_csr_if.sv
// Configuration write channel: the UTC offset register, valid/ready.
// Depends on utcl_pkg.
interface utcl_csr_if;
   logic                       valid;
   logic                       ready;
   logic [utcl_pkg::OFF_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

FILE: rtl/utcl_conv.sv
// Combinational UTC to local conversion of one date record.
// Clamps hour, month and day, zeroes an out-of-range offset, applies the offset and rolls day, month and year.
// Depends on utcl_pkg.
module utcl_conv (
   input  utcl_pkg::date_type          utc,
   input  logic [utcl_pkg::OFF_W-1:0]  offset,
   output utcl_pkg::date_type          local_date
);
   import utcl_pkg::*;

   localparam int PROD_W = YEAR_W + 13;
   localparam int SUM_W  = HOUR_W + 2;

   logic [PROD_W-1:0]  prod;
   logic               div4;
   logic               div100;
   logic               div400;
   logic               leap;
   logic signed [OFF_W-1:0] off_raw;
   logic signed [OFF_W-1:0] off;
   logic [HOUR_W-1:0]  hour;
   logic [MONTH_W-1:0] month;
   logic [MONTH_W-1:0] prev_month;
   logic [DAY_W-1:0]   dim;
   logic [DAY_W-1:0]   day;
   logic signed [SUM_W-1:0] sum;

   assign prod   = PROD_W'(utc.year) * PROD_W'(DIV100_MUL);
   assign div4   = (utc.year[1:0] == 2'b00);
   assign div100 = (prod[DIV100_SHIFT-1:9] == '0);
   assign div400 = div100 && (prod[DIV100_SHIFT+1:DIV100_SHIFT] == 2'b00);
   assign leap   = div4 && (!div100 || div400);

   always_comb begin
      off_raw = $signed(offset);
      if (off_raw < OFF_W'(OFF_MIN) || off_raw > OFF_W'(OFF_MAX)) begin
         off = '0;
      end else begin
         off = off_raw;
      end

      hour = (utc.hour > HOUR_W'(MAX_HOUR)) ? HOUR_W'(MAX_HOUR) : utc.hour;

      if (utc.month < JANUARY) begin
         month = JANUARY;
      end else if (utc.month > DECEMBER) begin
         month = DECEMBER;
      end else begin
         month = utc.month;
      end

      dim = month_days(month, leap);
      if (utc.day == '0) begin
         day = DAY_W'(1);
      end else if (utc.day > dim) begin
         day = dim;
      end else begin
         day = utc.day;
      end

      prev_month = (month == JANUARY) ? DECEMBER : month - MONTH_W'(1);
      sum = $signed({2'b00, hour}) + SUM_W'(off);

      local_date.year  = utc.year;
      local_date.month = month;
      local_date.day   = day;
      local_date.hour  = sum[HOUR_W-1:0];

      if (sum < 0) begin
         if (day > DAY_W'(1)) begin
            local_date.day = day - DAY_W'(1);
         end else begin
            local_date.month = prev_month;
            local_date.day   = month_days(prev_month, leap);
            if (month == JANUARY) begin
               local_date.year = utc.year - YEAR_W'(1);
            end
         end
         local_date.hour = HOUR_W'(sum + SUM_W'(HOURS_PER_DAY));
      end else if (sum >= SUM_W'(HOURS_PER_DAY)) begin
         if (day < dim) begin
            local_date.day = day + DAY_W'(1);
         end else begin
            local_date.day = DAY_W'(1);
            if (month < DECEMBER) begin
               local_date.month = month + MONTH_W'(1);
            end else begin
               local_date.month = JANUARY;
               local_date.year  = utc.year + YEAR_W'(1);
            end
         end
         local_date.hour = HOUR_W'(sum - SUM_W'(HOURS_PER_DAY));
      end
   end

endmodule

FILE: rtl/utc_to_local_date_hour.sv
// UTC to local date and hour converter, top level.
// Pipeline: an accepted request passes the input register, then the result
// register around one pass of the conversion logic.
// Throughput: one item per cycle; the pipeline stalls only on rsp.ready low.
// Reset: synchronous, active high; clears both stage valids, offset to 0.
// Depends on utcl_pkg, utcl_req_if, utcl_rsp_if, utcl_csr_if, utcl_conv.
module utc_to_local_date_hour (
   input  logic         clock,
   input  logic         reset,
   utcl_req_if.sink     req,
   utcl_rsp_if.source   rsp,
   utcl_csr_if.sink     csr
);
   import utcl_pkg::*;

   logic [OFF_W-1:0] offset_ff;
   logic             in_valid_ff;
   date_type         in_data_ff;
   logic             out_valid_ff;
   date_type         out_data_ff;
   date_type         out_data_in;
   logic             advance;

   assign advance   = !out_valid_ff || rsp.ready;
   assign req.ready = !in_valid_ff || advance;
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
      end else if (csr.valid) begin
         offset_ff <= csr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req.ready) begin
            in_valid_ff <= req.valid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.ready && req.valid) begin
         in_data_ff.year  <= req.utc_year;
         in_data_ff.month <= req.utc_month;
         in_data_ff.day   <= req.utc_day;
         in_data_ff.hour  <= req.utc_hour;
      end
      if (advance && in_valid_ff) begin
         out_data_ff <= out_data_in;
      end
   end

   utcl_conv u_conv (
      .utc        (in_data_ff),
      .offset     (offset_ff),
      .local_date (out_data_in)
   );

   assign rsp.valid       = out_valid_ff;
   assign rsp.local_year  = out_data_ff.year;
   assign rsp.local_month = out_data_ff.month;
   assign rsp.local_day   = out_data_ff.day;
   assign rsp.local_hour  = out_data_ff.hour;

endmodule
